[hdl/assert_macros.svh]
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define A4_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define A4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/adpcm4_pkg.sv]
`timescale 1ns / 1ps

package adpcm4_pkg;

    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int SMP_W     = 16;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 64;
    localparam int NUM_PAIRS = 8;
    localparam int CFG_IDX_W = $clog2(NUM_PAIRS);
    localparam int ENTRY_W   = 2 * COEF_W;
    localparam int PRED_IDX_W = CFG_IDX_W + 1;
    localparam int CNT_W     = 3;
    localparam int Q_SHIFT   = 11;

    localparam int PROD_W = COEF_W + SMP_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int PRED_W = ACC_W - Q_SHIFT;
    localparam int RES_W  = NIB_W + (1 << NIB_W) - 1;
    localparam int SUM_W  = ((PRED_W > RES_W) ? PRED_W : RES_W) + 1;

    localparam int SMP_MAX = 32767;
    localparam int SMP_MIN = -32768;

    localparam logic [CNT_W-1:0] BLOCK_LAST_CNT = CNT_W'(7);

    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_MUL_FIRST,
        MAC_MUL_SECOND,
        MAC_ADD
    } t_mac_op;

    typedef struct packed {
        t_mac_op            op;
        logic [NIB_W-1:0]   nibble;
        logic [NIB_W-1:0]   shift;
    } t_mac_ctrl;

    typedef struct packed {
        logic signed [COEF_W-1:0] newest;
        logic signed [COEF_W-1:0] older;
    } t_coef;

endpackage

[hdl/adpcm4_in_if.sv]
`timescale 1ns / 1ps

interface adpcm4_in_if import adpcm4_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [BYTE_W-1:0]        data_byte;
    logic                     is_header;
    logic                     reload_history;
    logic signed [SMP_W-1:0]  seed_newest;
    logic signed [SMP_W-1:0]  seed_older;

    modport source (
        output valid, data_byte, is_header, reload_history, seed_newest, seed_older,
        input  ready
    );
    modport sink (
        input  valid, data_byte, is_header, reload_history, seed_newest, seed_older,
        output ready
    );
endinterface

[hdl/adpcm4_out_if.sv]
`timescale 1ns / 1ps

interface adpcm4_out_if import adpcm4_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  first_sample;
    logic signed [SMP_W-1:0]  second_sample;
    logic                     block_last;

    modport source (
        output valid, first_sample, second_sample, block_last,
        input  ready
    );
    modport sink (
        input  valid, first_sample, second_sample, block_last,
        output ready
    );
endinterface

[hdl/adpcm4_coef_regs.sv]
`timescale 1ns / 1ps

module adpcm4_coef_regs import adpcm4_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_we,
    input  logic [CFG_IDX_W-1:0]   i_idx,
    input  logic [CFG_W-1:0]       i_data,
    input  logic [PRED_IDX_W-1:0]  i_pred_idx,
    output t_coef                  o_coef
);

    logic [CFG_W-1:0] r_pair [NUM_PAIRS];
    logic [CFG_W-1:0] pair_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PAIRS; k++) begin
                r_pair[k] <= '0;
            end
        end else if (i_we) begin
            r_pair[i_idx] <= i_data;
        end
    end

    assign pair_sel = r_pair[i_pred_idx[PRED_IDX_W-1:1]];
    assign o_coef   = i_pred_idx[0] ? t_coef'(pair_sel[2*ENTRY_W-1:ENTRY_W])
                                    : t_coef'(pair_sel[ENTRY_W-1:0]);

endmodule

[hdl/adpcm4_mac.sv]
`timescale 1ns / 1ps

module adpcm4_mac import adpcm4_pkg::*; (
    input  logic                     i_clk,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [COEF_W-1:0] i_coef,
    input  logic signed [SMP_W-1:0]  i_smp,
    output logic signed [SMP_W-1:0]  o_sum
);

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SMP_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SMP_MIN);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PRED_W-1:0] pred;
    logic signed [RES_W-1:0]  nib_ext;
    logic signed [RES_W-1:0]  resid;
    logic signed [SUM_W-1:0]  sum;

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            MAC_IDLE: begin
            end
            MAC_MUL_FIRST: begin
                r_prod <= i_coef * i_smp;
            end
            MAC_MUL_SECOND: begin
                r_prod <= i_coef * i_smp;
                r_acc  <= ACC_W'(r_prod);
            end
            MAC_ADD: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        endcase
    end

    always_comb begin
        pred    = $signed(r_acc[ACC_W-1:Q_SHIFT]);
        nib_ext = RES_W'($signed(i_ctrl.nibble));
        resid   = nib_ext <<< i_ctrl.shift;
        sum     = SUM_W'(pred) + SUM_W'(resid);
        if (sum > SAT_HI) begin
            o_sum = SMP_W'(SAT_HI);
        end else if (sum < SAT_LO) begin
            o_sum = SMP_W'(SAT_LO);
        end else begin
            o_sum = SMP_W'(sum);
        end
    end

endmodule

[hdl/adpcm4_block_decoder.sv]
`timescale 1ns / 1ps

// 4-bit ADPCM block decoder. Bytes arrive on the input channel; a byte marked
// is_header selects a predictor entry and scale (and may reload the history)
// and gives no result, with input ready left high. Each data byte gives one result
// with two samples. All arithmetic runs on one 16x16 multiplier-accumulator:
// each sample goes through four steps (newest product, older product, add,
// scale and saturate), and input ready stays low while a data byte is decoded.
// The result sits in an output register; a new byte is taken while it waits,
// and the block stalls only when a second result is ready before the first
// has been taken.
// Coefficient writes take effect at the next header byte.
module adpcm4_block_decoder import adpcm4_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    adpcm4_in_if.sink            i_byte_ch,
    adpcm4_out_if.source         o_smp_ch
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_N,
        S_MUL_O,
        S_ADD,
        S_SAT
    } t_state;

    t_state                    r_state;
    logic                      r_second;
    logic [BYTE_W-1:0]         r_byte;
    logic signed [COEF_W-1:0]  r_cn;
    logic signed [COEF_W-1:0]  r_co;
    logic [NIB_W-1:0]          r_shift;
    logic signed [SMP_W-1:0]   r_newest;
    logic signed [SMP_W-1:0]   r_older;
    logic [CNT_W-1:0]          r_count;
    logic signed [SMP_W-1:0]   r_first;
    logic                      r_out_valid;
    logic signed [SMP_W-1:0]   r_out_first;
    logic signed [SMP_W-1:0]   r_out_second;
    logic                      r_out_last;

    t_coef                     hdr_coef;
    t_mac_ctrl                 mac_ctrl;
    logic signed [COEF_W-1:0]  mac_coef;
    logic signed [SMP_W-1:0]   mac_smp;
    logic signed [SMP_W-1:0]   mac_sum;
    logic                      in_xfer;
    logic                      out_free;
    logic                      out_load;

    adpcm4_coef_regs u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (i_cfg_we),
        .i_idx      (i_cfg_idx),
        .i_data     (i_cfg_data),
        .i_pred_idx (i_byte_ch.data_byte[BYTE_W-1:NIB_W]),
        .o_coef     (hdr_coef)
    );

    adpcm4_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_coef (mac_coef),
        .i_smp  (mac_smp),
        .o_sum  (mac_sum)
    );

    assign i_byte_ch.ready = (r_state == S_IDLE);
    assign in_xfer         = i_byte_ch.valid && i_byte_ch.ready;
    assign out_free        = !r_out_valid || o_smp_ch.ready;
    assign out_load        = (r_state == S_SAT) && r_second && out_free;

    assign o_smp_ch.valid         = r_out_valid;
    assign o_smp_ch.first_sample  = r_out_first;
    assign o_smp_ch.second_sample = r_out_second;
    assign o_smp_ch.block_last    = r_out_last;

    always_comb begin
        mac_ctrl.nibble = r_second ? r_byte[NIB_W-1:0] : r_byte[BYTE_W-1:NIB_W];
        mac_ctrl.shift  = r_shift;
        mac_coef        = r_cn;
        mac_smp         = r_newest;
        unique case (r_state)
            S_MUL_N: mac_ctrl.op = MAC_MUL_FIRST;
            S_MUL_O: begin
                mac_ctrl.op = MAC_MUL_SECOND;
                mac_coef    = r_co;
                mac_smp     = r_older;
            end
            S_ADD:   mac_ctrl.op = MAC_ADD;
            default: mac_ctrl.op = MAC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_second    <= 1'b0;
            r_cn        <= '0;
            r_co        <= '0;
            r_shift     <= '0;
            r_newest    <= '0;
            r_older     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_smp_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_byte_ch.is_header) begin
                            r_cn    <= hdr_coef.newest;
                            r_co    <= hdr_coef.older;
                            r_shift <= i_byte_ch.data_byte[NIB_W-1:0];
                            r_count <= '0;
                            if (i_byte_ch.reload_history) begin
                                r_newest <= i_byte_ch.seed_newest;
                                r_older  <= i_byte_ch.seed_older;
                            end
                        end else begin
                            r_byte   <= i_byte_ch.data_byte;
                            r_second <= 1'b0;
                            r_state  <= S_MUL_N;
                        end
                    end
                end
                S_MUL_N: r_state <= S_MUL_O;
                S_MUL_O: r_state <= S_ADD;
                S_ADD:   r_state <= S_SAT;
                S_SAT: begin
                    if (!r_second) begin
                        r_older  <= r_newest;
                        r_newest <= mac_sum;
                        r_first  <= mac_sum;
                        r_second <= 1'b1;
                        r_state  <= S_MUL_N;
                    end else if (out_free) begin
                        r_older      <= r_newest;
                        r_newest     <= mac_sum;
                        r_out_first  <= r_first;
                        r_out_second <= mac_sum;
                        r_out_last   <= (r_count == BLOCK_LAST_CNT);
                        r_count      <= r_count + 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/adpcm4_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adpcm4_checker import adpcm4_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_in_is_header,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [SMP_W-1:0] i_out_first,
    input logic signed [SMP_W-1:0] i_out_second,
    input logic                    i_out_last
);

    `A4_ASSERT_NEXT(a_data_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_in_is_header, !i_in_ready, "data byte transfer did not drop ready")
    `A4_ASSERT_NEXT(a_hdr_no_result, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_is_header && !i_out_valid, !i_out_valid, "header byte produced a result")
    `A4_ASSERT_SAME(a_busy_no_ready, i_clk, i_rst_n, !i_in_ready && $past(i_in_valid && i_in_ready && !i_in_is_header), !$past(i_out_valid && !i_out_ready) || i_out_valid, "result lost while decoding")
    `A4_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_first) && $stable(i_out_second) && $stable(i_out_last), "stalled result changed")

endmodule

bind adpcm4_block_decoder adpcm4_checker u_adpcm4_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_byte_ch.valid),
    .i_in_ready     (i_byte_ch.ready),
    .i_in_is_header (i_byte_ch.is_header),
    .i_out_valid    (o_smp_ch.valid),
    .i_out_ready    (o_smp_ch.ready),
    .i_out_first    (o_smp_ch.first_sample),
    .i_out_second   (o_smp_ch.second_sample),
    .i_out_last     (o_smp_ch.block_last)
);
